>>> rtl/core/uri_query_tokenizer_unit_macros.svh
// ----------------------------------------------------------------------------
// URI query tokenizer assertion macros
// Shared concurrent assertion forms for the tokenizer checkers.
// ----------------------------------------------------------------------------
`ifndef URI_QUERY_TOKENIZER_UNIT_MACROS_SVH
`define URI_QUERY_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UQT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("uqt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UQT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("uqt assertion failed");

`endif

>>> rtl/core/uqt_pkg.sv
// ----------------------------------------------------------------------------
// URI query tokenizer package
// Result types, the bundle of results one byte produces, and queue sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uqt_pkg;

    // Depth of the bundle queue between the parser and the result sequencer.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Most results a single input byte can produce.
    localparam int MAX_RES = 3;

    typedef enum logic [2:0] {
        KIND_DATA       = 3'd0,
        KIND_ORIGIN_END = 3'd1,
        KIND_NAME_VAL   = 3'd2,
        KIND_NAME_FLAG  = 3'd3,
        KIND_VALUE_END  = 3'd4,
        KIND_DONE       = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ROLE_ORIGIN = 2'd0,
        ROLE_NAME   = 2'd1,
        ROLE_VALUE  = 2'd2
    } t_role;

    typedef enum logic [2:0] {
        MODE_SKIP   = 3'd0,
        MODE_ORIGIN = 3'd1,
        MODE_START  = 3'd2,
        MODE_NAME   = 3'd3,
        MODE_VALUE  = 3'd4
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        t_role       role;
        logic [7:0]  data;
    } t_res;

    // All results caused by one accepted byte, oldest in slot 0.
    typedef struct packed {
        logic [1:0]          cnt;
        t_res [MAX_RES-1:0]  res;
    } t_bundle;

    // Head of the queue as seen by the result sequencer.
    typedef struct packed {
        logic     valid;
        t_bundle  bundle;
    } t_q_head;

endpackage

>>> rtl/core/uqt_front.sv
// ----------------------------------------------------------------------------
// URI query tokenizer parser
// Takes one byte per transfer, runs the tokenizer state, builds a result bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uqt_front
    import uqt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_wr_en,
    output t_bundle     o_bundle
);

    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_QM   = 8'h3F;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_SP   = 8'h20;

    t_mode       r_mode,    n_mode;
    logic [1:0]  r_esc_cnt, n_esc_cnt;
    logic [7:0]  r_esc_val, n_esc_val;
    logic        r_esc_stop, n_esc_stop;
    logic        r_qfin,    n_qfin;

    t_bundle     bnd;
    logic        is_ws, is_end, do_tok;
    t_role       tok_role;
    logic [4:0]  hex;

    function automatic t_bundle add_res(t_bundle b, t_kind k, t_role r, logic [7:0] d);
        if (b.cnt < 2'(MAX_RES)) begin
            b.res[b.cnt] = '{kind: k, role: r, data: d};
            b.cnt        = b.cnt + 2'd1;
        end
        return b;
    endfunction

    // Returns the valid flag above the nibble value.
    function automatic logic [4:0] hex_of(logic [7:0] c);
        logic [4:0] h;
        h = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h = {1'b1, 4'(c - 8'h37)};
        end
        return h;
    endfunction

    assign is_ws  = (i_in_byte == CH_SP) || (i_in_byte == 8'h09) || (i_in_byte == 8'h0A) ||
                    (i_in_byte == 8'h0D) || (i_in_byte == 8'h0C) || (i_in_byte == 8'h0B);
    assign is_end = is_ws || (i_in_byte == CH_AMP) || (i_in_byte == CH_QM);
    assign hex    = hex_of(i_in_byte);

    always_comb begin
        n_mode     = r_mode;
        n_esc_cnt  = r_esc_cnt;
        n_esc_val  = r_esc_val;
        n_esc_stop = r_esc_stop;
        n_qfin     = r_qfin;
        bnd        = '0;
        do_tok     = 1'b0;
        tok_role   = ROLE_NAME;

        if (!r_qfin) begin
            case (r_mode)
                MODE_SKIP: begin
                    if (is_ws) begin
                        n_mode = MODE_SKIP;
                    end else if (i_in_byte == CH_QM) begin
                        n_mode = MODE_START;
                    end else begin
                        bnd    = add_res(bnd, KIND_DATA, ROLE_ORIGIN, i_in_byte);
                        n_mode = MODE_ORIGIN;
                    end
                end
                MODE_ORIGIN: begin
                    if (is_ws || i_in_byte == CH_QM) begin
                        bnd    = add_res(bnd, KIND_ORIGIN_END, ROLE_ORIGIN, 8'h00);
                        n_mode = MODE_START;
                    end else begin
                        bnd    = add_res(bnd, KIND_DATA, ROLE_ORIGIN, i_in_byte);
                    end
                end
                MODE_START: begin
                    if (is_ws) begin
                        n_qfin = 1'b1;
                    end else if (i_in_byte == CH_AMP || i_in_byte == CH_QM) begin
                        bnd    = add_res(bnd, KIND_NAME_FLAG, ROLE_NAME, 8'h00);
                    end else if (i_in_byte == CH_EQ) begin
                        bnd    = add_res(bnd, KIND_NAME_VAL, ROLE_NAME, 8'h00);
                        n_mode = MODE_VALUE;
                    end else begin
                        n_mode = MODE_NAME;
                        do_tok = 1'b1;
                    end
                end
                MODE_NAME: begin
                    if (is_end || i_in_byte == CH_EQ) begin
                        if (n_esc_cnt != 2'd0) begin
                            bnd        = add_res(bnd, KIND_DATA, ROLE_NAME, n_esc_val);
                            n_esc_cnt  = 2'd0;
                            n_esc_val  = 8'h00;
                            n_esc_stop = 1'b0;
                        end
                        if (is_end) begin
                            bnd    = add_res(bnd, KIND_NAME_FLAG, ROLE_NAME, 8'h00);
                            n_mode = MODE_START;
                        end else begin
                            bnd    = add_res(bnd, KIND_NAME_VAL, ROLE_NAME, 8'h00);
                            n_mode = MODE_VALUE;
                        end
                    end else begin
                        do_tok = 1'b1;
                    end
                end
                MODE_VALUE: begin
                    if (is_end) begin
                        if (n_esc_cnt != 2'd0) begin
                            bnd        = add_res(bnd, KIND_DATA, ROLE_VALUE, n_esc_val);
                            n_esc_cnt  = 2'd0;
                            n_esc_val  = 8'h00;
                            n_esc_stop = 1'b0;
                        end
                        bnd    = add_res(bnd, KIND_VALUE_END, ROLE_VALUE, 8'h00);
                        n_mode = MODE_START;
                    end else begin
                        tok_role = ROLE_VALUE;
                        do_tok   = 1'b1;
                    end
                end
                default: begin
                    n_mode     = MODE_SKIP;
                    n_esc_cnt  = 2'd0;
                    n_esc_val  = 8'h00;
                    n_esc_stop = 1'b0;
                end
            endcase
        end

        // Ordinary token character: escape digit handling or plain data.
        if (do_tok) begin
            if (n_esc_cnt != 2'd0) begin
                if (!n_esc_stop && hex[4]) begin
                    n_esc_val = {n_esc_val[3:0], hex[3:0]};
                end else begin
                    n_esc_stop = 1'b1;
                end
                if (n_esc_cnt >= 2'd2) begin
                    bnd        = add_res(bnd, KIND_DATA, tok_role, n_esc_val);
                    n_esc_cnt  = 2'd0;
                    n_esc_val  = 8'h00;
                    n_esc_stop = 1'b0;
                end else begin
                    n_esc_cnt = 2'd2;
                end
            end else if (i_in_byte == CH_PCT) begin
                n_esc_cnt  = 2'd1;
                n_esc_val  = 8'h00;
                n_esc_stop = 1'b0;
            end else begin
                bnd = add_res(bnd, KIND_DATA, tok_role,
                              (i_in_byte == CH_PLUS) ? CH_SP : i_in_byte);
            end
        end

        // Final byte closes the open token, reports done and rearms the parser.
        if (i_in_last) begin
            if (!n_qfin) begin
                if (n_mode == MODE_ORIGIN) begin
                    bnd = add_res(bnd, KIND_ORIGIN_END, ROLE_ORIGIN, 8'h00);
                end else if (n_mode == MODE_NAME) begin
                    if (n_esc_cnt != 2'd0) begin
                        bnd = add_res(bnd, KIND_DATA, ROLE_NAME, n_esc_val);
                    end
                    bnd = add_res(bnd, KIND_NAME_FLAG, ROLE_NAME, 8'h00);
                end else if (n_mode == MODE_VALUE) begin
                    if (n_esc_cnt != 2'd0) begin
                        bnd = add_res(bnd, KIND_DATA, ROLE_VALUE, n_esc_val);
                    end
                    bnd = add_res(bnd, KIND_VALUE_END, ROLE_VALUE, 8'h00);
                end
            end
            bnd        = add_res(bnd, KIND_DONE, ROLE_ORIGIN, 8'h00);
            n_mode     = MODE_SKIP;
            n_esc_cnt  = 2'd0;
            n_esc_val  = 8'h00;
            n_esc_stop = 1'b0;
            n_qfin     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_SKIP;
            r_esc_cnt  <= 2'd0;
            r_esc_val  <= 8'h00;
            r_esc_stop <= 1'b0;
            r_qfin     <= 1'b0;
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_esc_cnt  <= n_esc_cnt;
            r_esc_val  <= n_esc_val;
            r_esc_stop <= n_esc_stop;
            r_qfin     <= n_qfin;
        end
    end

    assign o_wr_en  = i_accept && (bnd.cnt != 2'd0);
    assign o_bundle = bnd;

endmodule

>>> rtl/core/uqt_fifo.sv
// ----------------------------------------------------------------------------
// URI query tokenizer bundle queue
// Short register queue of result bundles between parser and sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uqt_fifo
    import uqt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_wr_en,
    input  t_bundle  i_wr_data,
    input  logic     i_rd_en,
    output t_q_head  o_head,
    output logic     o_full
);

    t_bundle             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QPTR_W:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr_en) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd_en) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_wr_en, i_rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid  = (r_count != '0);
    assign o_head.bundle = r_mem[r_rptr];
    assign o_full        = (r_count == (QPTR_W+1)'(QDEPTH));

endmodule

>>> rtl/core/uqt_back.sv
// ----------------------------------------------------------------------------
// URI query tokenizer result sequencer
// Walks the slots of the head bundle and hands out one result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uqt_back
    import uqt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_head     i_head,
    input  logic        i_pop,
    output logic        o_rd_en,
    output logic        o_empty,
    output logic [2:0]  o_kind,
    output logic [1:0]  o_role,
    output logic [7:0]  o_byte,
    output logic        o_run_last
);

    logic [1:0]  r_idx;
    t_res        cur;
    logic        at_last, take;

    assign cur     = i_head.bundle.res[r_idx];
    assign at_last = (r_idx == (i_head.bundle.cnt - 2'd1));
    assign take    = i_pop && i_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= at_last ? 2'd0 : (r_idx + 2'd1);
        end
    end

    assign o_rd_en    = take && at_last;
    assign o_empty    = !i_head.valid;
    assign o_kind     = cur.kind;
    assign o_role     = cur.role;
    assign o_byte     = cur.data;
    assign o_run_last = at_last;

endmodule

>>> rtl/core/uri_query_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// URI query tokenizer
// Streaming splitter of URI text into origin, parameter names and values.
// ----------------------------------------------------------------------------
// Usage: raw URI bytes enter on the input queue port (push/full), one byte
// per transfer, with i_in_last set on the final byte of a text. Decoded
// results leave on the output queue port (empty/pop); each result carries a
// kind, a role, a byte and a flag marking the last result of its input byte.
// Throughput: one input byte per cycle while the queue is not full. The
// parser handles each byte in the cycle it is accepted; a byte may cause
// zero to three results, and the output side moves one result per cycle
// while the receiver pops, so bytes with several results drain at that
// rate through a four-entry bundle queue. A result appears on the output
// ports in the cycle after its byte is accepted, when the queue was empty.
// Reset (synchronous, active low) rearms the parser to skip leading
// whitespace and empties the queue. If the receiver stalls, results wait in
// the queue and full rises once it holds four bundles; input bytes that
// cause no result are still accepted while the queue has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uri_query_tokenizer_unit
    import uqt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_out_kind,
    output logic [1:0]  o_out_role,
    output logic [7:0]  o_out_byte,
    output logic        o_out_run_last
);

    logic     accept;
    logic     wr_en, rd_en;
    t_bundle  bundle;
    t_q_head  head;

    // An input transfer happens whenever the queue has room for a bundle.
    assign accept = push && !full;

    uqt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_wr_en   (wr_en),
        .o_bundle  (bundle)
    );

    uqt_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_data (bundle),
        .i_rd_en   (rd_en),
        .o_head    (head),
        .o_full    (full)
    );

    // The sequencer retires a bundle after the transfer of its last result.
    uqt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_pop      (pop),
        .o_rd_en    (rd_en),
        .o_empty    (empty),
        .o_kind     (o_out_kind),
        .o_role     (o_out_role),
        .o_byte     (o_out_byte),
        .o_run_last (o_out_run_last)
    );

endmodule

>>> rtl/core/uqt_checker.sv
// ----------------------------------------------------------------------------
// URI query tokenizer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uri_query_tokenizer_unit_macros.svh"

module uqt_checker
    import uqt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  o_out_kind,
    input  logic [1:0]  o_out_role,
    input  logic [7:0]  o_out_byte,
    input  logic        o_out_run_last
);

    logic any_push;
    logic out_valid;
    logic is_marker;
    logic is_done;
    logic is_end_kind;
    logic end_role_ok;

    assign any_push    = push || full;
    assign out_valid   = !empty;
    assign is_marker   = (o_out_kind != KIND_DATA);
    assign is_done     = (o_out_kind == KIND_DONE);
    assign is_end_kind = (o_out_kind == KIND_ORIGIN_END) || (o_out_kind == KIND_VALUE_END);
    assign end_role_ok = ((o_out_kind == KIND_ORIGIN_END) && (o_out_role == ROLE_ORIGIN)) ||
                         ((o_out_kind == KIND_VALUE_END) && (o_out_role == ROLE_VALUE));

    // Markers carry no byte.
    `UQT_ASSERT_SAME(a_marker_zero, i_clk, i_rst_n, out_valid && is_marker, o_out_byte == 8'h00)

    // Text done always closes the run of its byte.
    `UQT_ASSERT_SAME(a_done_last, i_clk, i_rst_n, out_valid && is_done, o_out_run_last)

    // Value end and origin end carry their own role.
    `UQT_ASSERT_SAME(a_end_role, i_clk, i_rst_n, out_valid && is_end_kind, end_role_ok)

    // A run that is not finished keeps results waiting after a transfer.
    `UQT_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, pop && out_valid && !o_out_run_last, out_valid)

    // Nothing can arrive on the output without an earlier input transfer.
    `UQT_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !out_valid && !any_push && !pop, !out_valid)

endmodule

bind uri_query_tokenizer_unit uqt_checker u_uqt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_out_kind     (o_out_kind),
    .o_out_role     (o_out_role),
    .o_out_byte     (o_out_byte),
    .o_out_run_last (o_out_run_last)
);

>>> verif/tb_uri_query_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// URI query tokenizer testbench
// Sends URI texts one byte per transfer, predicts every decoded byte and end
// marker in a behavioral tokenizer, and checks each result that leaves the
// block against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uri_query_tokenizer_unit
    import uqt_pkg::*;
();

    // Characters that steer the tokenizer.
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TOP   = 8'hFF;

    localparam int MAX_RESULTS   = 3;
    localparam int DRAIN_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 250000;
    localparam int MAX_REPORTS   = 30;
    localparam int RANDOM_BYTES  = 400;
    localparam int PHASE_BYTES   = 50;

    localparam string PLAIN_SET = "abcmxyzAMZ0159_-.~/:";
    localparam string HEX_SET   = "0123456789abcdefABCDEF";

    // How the receiver paces its pops.
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_STALLS
    } t_rx_pattern;

    typedef struct {
        t_kind      kind;
        t_role      role;
        logic [7:0] data;
        logic       run_last;
    } t_tok_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [2:0] o_out_kind;
    logic [1:0] o_out_role;
    logic [7:0] o_out_byte;
    logic       o_out_run_last;

    uri_query_tokenizer_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .empty          (empty),
        .pop            (pop),
        .o_out_kind     (o_out_kind),
        .o_out_role     (o_out_role),
        .o_out_byte     (o_out_byte),
        .o_out_run_last (o_out_run_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Behavioral tokenizer. Its state mirrors the block's parser: the parse
    // mode, the pending percent escape and the flag that the query is over.
    // ------------------------------------------------------------------------
    t_mode       tok_mode = MODE_SKIP;
    logic [1:0]  esc_slots = 2'd0;
    logic [7:0]  esc_acc = 8'h00;
    logic        esc_bad = 1'b0;
    logic        query_done = 1'b0;

    t_tok_result step_results[$];
    t_tok_result tokens_due[$];
    int          parsed_bytes = 0;
    int          err_count = 0;

    function automatic logic is_space(logic [7:0] ch);
        return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    function automatic int hex_value(logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return int'(ch - "0");
        if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
        if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
        return -1;
    endfunction

    // A byte can cause at most three results; anything beyond is lost.
    function automatic void add_result(t_kind kind, t_role role, logic [7:0] data);
        if (step_results.size() < MAX_RESULTS) begin
            step_results.push_back('{kind: kind, role: role, data: data, run_last: 1'b0});
        end
    endfunction

    function automatic void clear_escape();
        esc_slots = 2'd0;
        esc_acc = 8'h00;
        esc_bad = 1'b0;
    endfunction

    // An escape that is closed, completed or cut short yields one byte built
    // from whatever hex digits it gathered.
    function automatic void flush_escape(t_role role);
        if (esc_slots != 2'd0) begin
            add_result(KIND_DATA, role, esc_acc);
            clear_escape();
        end
    endfunction

    function automatic void reset_tokenizer();
        tok_mode = MODE_SKIP;
        clear_escape();
        query_done = 1'b0;
    endfunction

    // One byte inside a name or value: escape digit, escape start, or data.
    function automatic void take_token_char(t_role role, logic [7:0] ch);
        int digit;
        digit = hex_value(ch);
        if (esc_slots != 2'd0) begin
            // The first non-hex byte freezes the value; later slots add nothing.
            if (!esc_bad && digit >= 0) begin
                esc_acc = {esc_acc[3:0], 4'(digit)};
            end else begin
                esc_bad = 1'b1;
            end
            if (esc_slots >= 2'd2) begin
                flush_escape(role);
            end else begin
                esc_slots = 2'd2;
            end
        end else if (ch == CH_PCT) begin
            clear_escape();
            esc_slots = 2'd1;
        end else begin
            add_result(KIND_DATA, role, (ch == CH_PLUS) ? CH_SPACE : ch);
        end
    endfunction

    // Predicts all results of one accepted byte and queues them in order.
    function automatic void tokenize_byte(logic [7:0] ch, logic last);
        logic        closes_token;
        t_tok_result res;
        closes_token = (ch == CH_AMP) || (ch == CH_QMARK) || is_space(ch);
        step_results.delete();
        if (!query_done) begin
            parsed_bytes++;
            case (tok_mode)
                MODE_SKIP: begin
                    if (is_space(ch)) begin
                        // Leading whitespace is dropped.
                    end else if (ch == CH_QMARK) begin
                        tok_mode = MODE_START;
                    end else begin
                        add_result(KIND_DATA, ROLE_ORIGIN, ch);
                        tok_mode = MODE_ORIGIN;
                    end
                end
                MODE_ORIGIN: begin
                    // The origin is passed through raw, with no decoding.
                    if (ch == CH_QMARK || is_space(ch)) begin
                        add_result(KIND_ORIGIN_END, ROLE_ORIGIN, 8'h00);
                        tok_mode = MODE_START;
                    end else begin
                        add_result(KIND_DATA, ROLE_ORIGIN, ch);
                    end
                end
                MODE_START: begin
                    if (is_space(ch)) begin
                        query_done = 1'b1;
                    end else if (ch == CH_AMP || ch == CH_QMARK) begin
                        add_result(KIND_NAME_FLAG, ROLE_NAME, 8'h00);
                    end else if (ch == CH_EQ) begin
                        add_result(KIND_NAME_VAL, ROLE_NAME, 8'h00);
                        tok_mode = MODE_VALUE;
                    end else begin
                        tok_mode = MODE_NAME;
                        take_token_char(ROLE_NAME, ch);
                    end
                end
                MODE_NAME: begin
                    if (closes_token) begin
                        flush_escape(ROLE_NAME);
                        add_result(KIND_NAME_FLAG, ROLE_NAME, 8'h00);
                        tok_mode = MODE_START;
                    end else if (ch == CH_EQ) begin
                        flush_escape(ROLE_NAME);
                        add_result(KIND_NAME_VAL, ROLE_NAME, 8'h00);
                        tok_mode = MODE_VALUE;
                    end else begin
                        take_token_char(ROLE_NAME, ch);
                    end
                end
                MODE_VALUE: begin
                    if (closes_token) begin
                        flush_escape(ROLE_VALUE);
                        add_result(KIND_VALUE_END, ROLE_VALUE, 8'h00);
                        tok_mode = MODE_START;
                    end else begin
                        take_token_char(ROLE_VALUE, ch);
                    end
                end
                default: begin
                    tok_mode = MODE_SKIP;
                    clear_escape();
                end
            endcase
        end
        if (last) begin
            // The final byte closes the open token, then marks the text done.
            if (!query_done) begin
                if (tok_mode == MODE_ORIGIN) begin
                    add_result(KIND_ORIGIN_END, ROLE_ORIGIN, 8'h00);
                end else if (tok_mode == MODE_NAME) begin
                    flush_escape(ROLE_NAME);
                    add_result(KIND_NAME_FLAG, ROLE_NAME, 8'h00);
                end else if (tok_mode == MODE_VALUE) begin
                    flush_escape(ROLE_VALUE);
                    add_result(KIND_VALUE_END, ROLE_VALUE, 8'h00);
                end
            end
            add_result(KIND_DONE, ROLE_ORIGIN, 8'h00);
            reset_tokenizer();
        end
        for (int i = 0; i < step_results.size(); i++) begin
            res = step_results[i];
            res.run_last = (i == step_results.size() - 1);
            tokens_due.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking. Each popped result is matched field by field against
    // the oldest predicted one.
    // ------------------------------------------------------------------------
    function automatic void report_mismatch(string field, logic [7:0] want,
                                            logic [7:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endfunction

    function automatic void check_result();
        t_tok_result want;
        if (tokens_due.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
                $display("%0t: unexpected result, expected none, actual kind %0d role %0d byte %0h",
                         $time, o_out_kind, o_out_role, o_out_byte);
            end
            return;
        end
        want = tokens_due.pop_front();
        if (o_out_kind !== want.kind) report_mismatch("kind", 8'(want.kind), 8'(o_out_kind));
        if (o_out_role !== want.role) report_mismatch("role", 8'(want.role), 8'(o_out_role));
        if (o_out_byte !== want.data) report_mismatch("byte", want.data, o_out_byte);
        if (o_out_run_last !== want.run_last) begin
            report_mismatch("run_last", 8'(want.run_last), 8'(o_out_run_last));
        end
    endfunction

    // Both handshakes are sampled at the rising edge, before the block's own
    // registers update, so a transfer is seen exactly once. Checking runs
    // first; a byte accepted at this edge cannot have a result out yet.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) check_result();
            if (push && !full) tokenize_byte(i_in_byte, i_in_last);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver pacing: pops every cycle, at random, or in long stalls.
    // ------------------------------------------------------------------------
    t_rx_pattern rx_pattern = RX_ALWAYS;
    int          stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            case (rx_pattern)
                RX_ALWAYS: begin
                    pop <= 1'b1;
                end
                RX_COIN: begin
                    pop <= ($urandom_range(0, 2) != 0);
                end
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        pop <= 1'b0;
                    end else begin
                        pop <= 1'b1;
                        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(3, 20);
                    end
                end
            endcase
        end
    end

    // Watchdog against a hung handshake.
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, tokens_due.size());
            $display("** uri_query_tokenizer_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Bytes go out in bursts of random length; after a burst the push
    // line may drop for a random gap no longer than gap_max.
    // ------------------------------------------------------------------------
    int          gap_max = 0;
    int          burst_left = 0;
    logic [7:0]  text_buf[$];

    task automatic send_byte(input logic [7:0] ch, input logic last);
        int gap;
        push <= 1'b1;
        i_in_byte <= ch;
        i_in_last <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 7);
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Holds the input off until every predicted result has been popped.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sends text_buf as one text, flagging its final byte. A pause index
    // stops the sender mid-text until the output side has drained.
    task automatic send_text(input int pause_at);
        for (int i = 0; i < text_buf.size(); i++) begin
            if (i == pause_at) drain_results();
            send_byte(text_buf[i], i == text_buf.size() - 1);
        end
        text_buf.delete();
    endtask

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_char(string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic logic [7:0] space_char();
        if ($urandom_range(0, 1) == 0) return CH_SPACE;
        return 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    // Any byte that does not end a token or start a value.
    function automatic logic [7:0] loose_char();
        logic [7:0] ch;
        do begin
            ch = 8'($urandom_range(0, 255));
        end while (is_space(ch) || ch == CH_AMP || ch == CH_QMARK || ch == CH_EQ);
        return ch;
    endfunction

    // Random name or value content, rich in escapes, broken escapes and '+'.
    function automatic void add_token(logic in_value, int len);
        int pick;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                text_buf.push_back(pick_char(PLAIN_SET));
            end else if (pick < 50) begin
                text_buf.push_back(CH_PLUS);
            end else if (pick < 62) begin
                text_buf.push_back(CH_PCT);
                text_buf.push_back(pick_char(HEX_SET));
                text_buf.push_back(pick_char(HEX_SET));
            end else if (pick < 68) begin
                text_buf.push_back(CH_PCT);
                text_buf.push_back(pick_char(HEX_SET));
                text_buf.push_back(pick_char("gZ%+._"));
            end else if (pick < 72) begin
                // A lone escape start, often cut short by what follows.
                text_buf.push_back(CH_PCT);
            end else if (pick < 78) begin
                text_buf.push_back(in_value ? CH_EQ : pick_char(PLAIN_SET));
            end else begin
                text_buf.push_back(loose_char());
            end
        end
    endfunction

    // A well-formed URI with random content, sometimes followed by
    // whitespace and random trailing bytes.
    function automatic void build_uri();
        int count;
        count = $urandom_range(0, 2);
        repeat (count) text_buf.push_back(space_char());
        if ($urandom_range(0, 6) != 0) begin
            count = $urandom_range(1, 6);
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    text_buf.push_back(loose_char());
                end else begin
                    text_buf.push_back(pick_char(PLAIN_SET));
                end
            end
        end
        if ($urandom_range(0, 4) != 0) begin
            text_buf.push_back(CH_QMARK);
            count = $urandom_range(0, 4);
            for (int i = 0; i < count; i++) begin
                add_token(1'b0, $urandom_range(0, 4));
                if ($urandom_range(0, 9) < 7) begin
                    text_buf.push_back(CH_EQ);
                    add_token(1'b1, $urandom_range(0, 5));
                end
                if (i < count - 1) begin
                    text_buf.push_back(($urandom_range(0, 5) == 0) ? CH_QMARK : CH_AMP);
                end
            end
        end
        if ($urandom_range(0, 6) == 0) begin
            text_buf.push_back(space_char());
            count = $urandom_range(1, 3);
            repeat (count) text_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (text_buf.size() == 0) text_buf.push_back(pick_char(PLAIN_SET));
    endfunction

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Leading whitespace, a raw origin with '%' and '+', a decoded name, an
    // escape cut short by '=', a non-hex escape, an empty name with a value,
    // '=' and byte zero inside a value, and byte 0xFF as a final flag name.
    // The sender also pauses once in the middle until the output drains.
    task automatic test_origin_and_parameters();
        gap_max = 0;
        rx_pattern = RX_ALWAYS;
        add_str(" o%+?%41&%4=b+%zz&=v");
        text_buf.push_back(CH_NUL);
        add_str("= ");
        text_buf.push_back(CH_TOP);
        send_text(10);
    endtask

    // A text that opens with '?', a bare delimiter giving an empty flag, and
    // whitespace at a token start that ends the query; the rest is ignored.
    task automatic test_flags_and_finished_query();
        gap_max = 2;
        rx_pattern = RX_COIN;
        add_str("?&\t");
        text_buf.push_back(CH_NUL);
        add_str("x");
        send_text(-1);
    endtask

    // A text of whitespace alone yields only the done marker.
    task automatic test_blank_text();
        add_str(" \t");
        send_text(-1);
    endtask

    // A final '=' that cuts short an escape in a name would cause four
    // results; the done marker is the one that is lost.
    task automatic test_result_overflow();
        rx_pattern = RX_STALLS;
        add_str("?%A=");
        send_text(-1);
    endtask

    // End of text closes an origin, and a value with a bare escape pending.
    task automatic test_closing_at_end();
        add_str("u");
        send_text(-1);
        add_str("?k=%");
        send_text(-1);
    endtask

    // ------------------------------------------------------------------------
    // Random texts in phases of different pacing, from no idling at all to
    // long receiver stalls and mid-text pauses until the output drains.
    // ------------------------------------------------------------------------
    task automatic test_random_texts();
        int goal;
        int phase_goal;
        int phase;
        int pause_at;
        goal = parsed_bytes + RANDOM_BYTES;
        phase = 0;
        while (parsed_bytes < goal) begin
            case (phase % 4)
                0: begin
                    gap_max = 0;
                    rx_pattern = RX_ALWAYS;
                end
                1: begin
                    gap_max = 3;
                    rx_pattern = RX_COIN;
                end
                2: begin
                    gap_max = 8;
                    rx_pattern = RX_STALLS;
                end
                default: begin
                    gap_max = 2;
                    rx_pattern = RX_COIN;
                end
            endcase
            phase_goal = parsed_bytes + PHASE_BYTES;
            while (parsed_bytes < phase_goal) begin
                if ($urandom_range(0, 4) != 0) begin
                    build_uri();
                end else begin
                    // Noise: arbitrary bytes, any of which may be the last.
                    repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
                end
                pause_at = -1;
                if (phase % 4 == 3 && $urandom_range(0, 2) == 0) begin
                    pause_at = $urandom_range(0, text_buf.size() - 1);
                end
                send_text(pause_at);
            end
            phase++;
        end
    endtask

    initial begin
        reset_tokenizer();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_origin_and_parameters();
        test_flags_and_finished_query();
        test_blank_text();
        test_result_overflow();
        test_closing_at_end();
        test_random_texts();

        drain_results();
        if (tokens_due.size() != 0) begin
            err_count++;
            $display("%0t: %0d expected results never arrived", $time, tokens_due.size());
        end
        if (err_count == 0) begin
            $display("** uri_query_tokenizer_unit: PASSED **");
        end else begin
            $display("** uri_query_tokenizer_unit: FAILED **");
        end
        $finish;
    end

endmodule
